FILE: src/lpfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

  // Longest frame whose data bytes are passed on
  localparam logic [7:0] MAX_DATA = 8'd128;

  // Parser position: which byte of the frame comes next
  typedef enum logic [2:0] {
    PH_LEN    = 3'd0,
    PH_ADDR_H = 3'd1,
    PH_ADDR_L = 3'd2,
    PH_CMD    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CSUM   = 3'd5
  } phase_t;

  // Result kind carried on tuser
  typedef enum logic [2:0] {
    KIND_DATA = 3'd0,
    KIND_OK   = 3'd1,
    KIND_CSUM = 3'd2,
    KIND_ZERO = 3'd3,
    KIND_LONG = 3'd4
  } kind_t;

  // One result transaction
  typedef struct packed {
    logic [7:0]  payload_length;
    logic [15:0] target_address;
    logic [7:0]  command_code;
    logic [6:0]  data_index;
    logic [7:0]  data_byte;
  } result_t;

endpackage

`default_nettype wire

FILE: src/length_prefixed_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Parses a byte stream into frames of the form length, address high, address
// low, command, <length> data bytes, checksum, where the checksum makes the
// 8-bit sum of all frame bytes zero. Each data byte comes out as it arrives
// with its index; the checksum byte yields one status transaction (ok,
// checksum error, or too long when the length exceeds 128, in which case data
// is swallowed). A zero length byte is reported at once and skipped. One byte
// is taken every clock unless the output stalls: the parser state and the
// result are updated together, the result into an output register, and a new
// byte is accepted whenever that register is empty or being drained, so results
// appear in the cycle after their byte, one byte per cycle when not stalled.
module length_prefixed_frame_receiver (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  // [7:0] data_byte, [14:8] data_index, [22:15] command_code,
  // [38:23] target_address, [46:39] payload_length, [47] zero
  output logic [47:0] out_tdata,
  output logic [2:0]  out_tuser   // [2:0] kind
);

  lpfr_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        frame_length_r, frame_length_nxt;
  logic [15:0]       frame_address_r, frame_address_nxt;
  logic [7:0]        frame_command_r, frame_command_nxt;
  logic [7:0]        data_count_r, data_count_nxt;
  logic [7:0]        running_sum_r, running_sum_nxt;

  logic              out_valid_r;
  lpfr_pkg::kind_t   out_kind_r;
  lpfr_pkg::result_t out_res_r;

  logic              in_fire;
  logic              res_valid;
  lpfr_pkg::kind_t   res_kind;
  lpfr_pkg::result_t res;
  logic              too_long;
  logic [7:0]        sum_in;
  logic [7:0]        count_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign too_long  = frame_length_r > lpfr_pkg::MAX_DATA;
  assign sum_in    = running_sum_r + in_tdata;
  assign count_inc = data_count_r + 8'd1;

  // Advance the parser position
  always_comb begin
    case (phase_r)
      lpfr_pkg::PH_ADDR_H: phase_nxt = lpfr_pkg::PH_ADDR_L;
      lpfr_pkg::PH_ADDR_L: phase_nxt = lpfr_pkg::PH_CMD;
      lpfr_pkg::PH_CMD:    phase_nxt = lpfr_pkg::PH_DATA;
      lpfr_pkg::PH_DATA: begin
        phase_nxt = (count_inc >= frame_length_r) ? lpfr_pkg::PH_CSUM : lpfr_pkg::PH_DATA;
      end
      lpfr_pkg::PH_CSUM:   phase_nxt = lpfr_pkg::PH_LEN;
      default: begin
        phase_nxt = (in_tdata == 8'd0) ? lpfr_pkg::PH_LEN : lpfr_pkg::PH_ADDR_H;
      end
    endcase
  end

  // Update frame fields, sum and count; form the result
  always_comb begin
    frame_length_nxt  = frame_length_r;
    frame_address_nxt = frame_address_r;
    frame_command_nxt = frame_command_r;
    data_count_nxt    = data_count_r;
    running_sum_nxt   = sum_in;
    res_valid         = 1'b0;
    res_kind          = lpfr_pkg::KIND_DATA;
    res.data_byte     = 8'd0;
    res.data_index    = 7'd0;
    case (phase_r)
      lpfr_pkg::PH_ADDR_H: frame_address_nxt = {in_tdata, 8'd0};
      lpfr_pkg::PH_ADDR_L: frame_address_nxt = {frame_address_r[15:8], in_tdata};
      lpfr_pkg::PH_CMD: begin
        frame_command_nxt = in_tdata;
        data_count_nxt    = 8'd0;
      end
      lpfr_pkg::PH_DATA: begin
        data_count_nxt = count_inc;
        res_valid      = !too_long;
        res.data_byte  = in_tdata;
        res.data_index = data_count_r[6:0];
      end
      lpfr_pkg::PH_CSUM: begin
        res_valid       = 1'b1;
        data_count_nxt  = 8'd0;
        running_sum_nxt = 8'd0;
        if (too_long) begin
          res_kind = lpfr_pkg::KIND_LONG;
        end else if (sum_in == 8'd0) begin
          res_kind = lpfr_pkg::KIND_OK;
        end else begin
          res_kind = lpfr_pkg::KIND_CSUM;
        end
      end
      default: begin
        data_count_nxt  = 8'd0;
        running_sum_nxt = in_tdata;
        frame_length_nxt = in_tdata;
        if (in_tdata == 8'd0) begin
          frame_address_nxt = 16'd0;
          frame_command_nxt = 8'd0;
          res_valid         = 1'b1;
          res_kind          = lpfr_pkg::KIND_ZERO;
        end
      end
    endcase
    res.command_code   = frame_command_nxt;
    res.target_address = frame_address_nxt;
    res.payload_length = frame_length_nxt;
  end

  // Hold parser state; advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= lpfr_pkg::PH_LEN;
      frame_length_r  <= 8'd0;
      frame_address_r <= 16'd0;
      frame_command_r <= 8'd0;
      data_count_r    <= 8'd0;
      running_sum_r   <= 8'd0;
    end else if (in_fire) begin
      phase_r         <= phase_nxt;
      frame_length_r  <= frame_length_nxt;
      frame_address_r <= frame_address_nxt;
      frame_command_r <= frame_command_nxt;
      data_count_r    <= data_count_nxt;
      running_sum_r   <= running_sum_nxt;
    end
  end

  // Load the output register whenever it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      out_kind_r <= res_kind;
      out_res_r  <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_res_r};

`ifndef SYNTHESIS
  // A zero length byte is reported in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == lpfr_pkg::PH_LEN && in_tdata == 8'd0
    |=> out_tvalid && out_tuser == lpfr_pkg::KIND_ZERO)
    else $error("zero length byte not reported");

  // Data transactions only come from frames within the length limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lpfr_pkg::KIND_DATA
    |-> out_tdata[46:39] <= lpfr_pkg::MAX_DATA && out_tdata[46:39] != 8'd0)
    else $error("data transaction from an oversized or empty frame");

  // Zero length reports carry cleared frame fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lpfr_pkg::KIND_ZERO
    |-> out_tdata[46:15] == 32'd0)
    else $error("zero length report with stale frame fields");

  // Waiting for a length byte means sum and count are cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lpfr_pkg::PH_LEN |-> data_count_r == 8'd0 && running_sum_r == 8'd0)
    else $error("frame accumulators not cleared between frames");

  // The data count never passes the frame length
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lpfr_pkg::PH_DATA |-> data_count_r < frame_length_r)
    else $error("data count overran frame length");
`endif

endmodule

`default_nettype wire
